### hdl/nbbr_pkg.sv
// Package for the bad-block remap translator: field widths, codes, reset values
// and the word types that pass between the front end, the queues and the back end.
// Depends on nothing.
package nbbr_pkg;

    // Default values of the top-level parameters
    localparam int DEF_MAX_BLOCKS      = 8192;
    localparam int DEF_PAGES_PER_BLOCK = 32;
    localparam int DEF_BLOCKS_PER_MB   = 64;

    // Fixed field widths
    localparam int BLK_W     = 13;
    localparam int MARK_W    = 8;
    localparam int PART_W    = 2;
    localparam int SECTOR_W  = 18;
    localparam int PAGE_W    = 18;
    localparam int BADCNT_W  = 14;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Widths that cover every legal parameter value
    localparam int VBLK_W = 14;  // virtual block index, up to 16384 blocks
    localparam int BASE_W = 18;  // partition base and limit in blocks
    localparam int OFF_W  = 7;   // page within a block, up to 128 pages

    localparam logic [MARK_W-1:0]   GOOD_MARK = 8'hFF;
    localparam logic [BADCNT_W-1:0] COUNT_MAX = 14'h3FFF;
    localparam int                  PAGE_MAX  = 262143;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMDISK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERAL = 2'd2;

    localparam logic [CFG_W-1:0] RST_KERNEL_MB  = 8'd1;
    localparam logic [CFG_W-1:0] RST_RAMDISK_MB = 8'd3;
    localparam logic [CFG_W-1:0] RST_GENERAL_MB = 8'd124;

    // Partition numbers
    localparam logic [PART_W-1:0] PART_KERNEL  = 2'd0;
    localparam logic [PART_W-1:0] PART_RAMDISK = 2'd1;
    localparam logic [PART_W-1:0] PART_GENERAL = 2'd2;

    typedef enum logic {
        FUNC_SCAN  = 1'b0,
        FUNC_XLATE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        RC_OK       = 2'd0,
        RC_BAD_PART = 2'd1,
        RC_UNMAPPED = 2'd2,
        RC_RANGE    = 2'd3
    } t_rc;

    // Classified command, front end to back end
    typedef struct packed {
        t_func              func;
        logic               restart;
        logic               bad;
        logic [BLK_W-1:0]   blk;
        t_rc                rc;
        logic [VBLK_W-1:0]  vblk;
        logic [BASE_W-1:0]  base;
        logic [BASE_W-1:0]  limit;
        logic [OFF_W-1:0]   off;
    } t_cmd;

    // Result word, back end to output queue
    typedef struct packed {
        t_rc                  result_code;
        logic                 block_bad;
        logic [PAGE_W-1:0]    page;
        logic [BADCNT_W-1:0]  bad_count;
    } t_res;

endpackage

### hdl/nbbr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module nbbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/nbbr_fifo.sv
// Small flip-flop queue used between the stages of the translator.
// Depends on nothing.
module nbbr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/nbbr_front.sv
// Front end of the translator: classifies an input word and works out the
// partition window and virtual block. Depends on nbbr_pkg.
module nbbr_front #(
    parameter int MAX_BLOCKS      = nbbr_pkg::DEF_MAX_BLOCKS,
    parameter int PAGES_PER_BLOCK = nbbr_pkg::DEF_PAGES_PER_BLOCK,
    parameter int BLOCKS_PER_MB   = nbbr_pkg::DEF_BLOCKS_PER_MB
) (
    input  logic                          i_func,
    input  logic [nbbr_pkg::BLK_W-1:0]    i_block_index,
    input  logic [nbbr_pkg::MARK_W-1:0]   i_marker_byte,
    input  logic [nbbr_pkg::PART_W-1:0]   i_partition,
    input  logic [nbbr_pkg::SECTOR_W-1:0] i_sector,
    input  logic [nbbr_pkg::CFG_W-1:0]    i_kernel_mb,
    input  logic [nbbr_pkg::CFG_W-1:0]    i_ramdisk_mb,
    input  logic [nbbr_pkg::CFG_W-1:0]    i_general_mb,
    output nbbr_pkg::t_cmd                o_cmd
);

    import nbbr_pkg::*;

    // Pages per block is a power of two: split the sector by shift and mask
    localparam int OFF_SH = $clog2(PAGES_PER_BLOCK);

    logic [BASE_W-1:0] kernel_blks, ramdisk_blks, general_blks;
    logic [BASE_W-1:0] base, limit;
    logic              part_ok;
    logic [BASE_W:0]   vblk_sum;

    assign kernel_blks  = BASE_W'(i_kernel_mb) * BASE_W'(BLOCKS_PER_MB);
    assign ramdisk_blks = BASE_W'(i_ramdisk_mb) * BASE_W'(BLOCKS_PER_MB);
    assign general_blks = BASE_W'(i_general_mb) * BASE_W'(BLOCKS_PER_MB);

    always_comb begin
        part_ok = 1'b1;
        case (i_partition)
            PART_KERNEL: begin
                base  = '0;
                limit = kernel_blks;
            end
            PART_RAMDISK: begin
                base  = kernel_blks;
                limit = kernel_blks + ramdisk_blks;
            end
            PART_GENERAL: begin
                base  = kernel_blks + ramdisk_blks;
                limit = kernel_blks + ramdisk_blks + general_blks;
            end
            default: begin
                base    = '0;
                limit   = '0;
                part_ok = 1'b0;
            end
        endcase
    end

    assign vblk_sum = {1'b0, base} + (BASE_W + 1)'(i_sector >> OFF_SH);

    always_comb begin
        o_cmd.func    = t_func'(i_func);
        o_cmd.restart = (i_block_index == '0);
        o_cmd.bad     = (i_marker_byte != GOOD_MARK);
        o_cmd.blk     = i_block_index;
        o_cmd.vblk    = vblk_sum[VBLK_W-1:0];
        o_cmd.base    = base;
        o_cmd.limit   = limit;
        o_cmd.off     = OFF_W'(i_sector & SECTOR_W'(PAGES_PER_BLOCK - 1));
        if (!part_ok) begin
            o_cmd.rc = RC_BAD_PART;
        end else if (vblk_sum >= (BASE_W + 1)'(MAX_BLOCKS)) begin
            o_cmd.rc = RC_RANGE;
        end else begin
            o_cmd.rc = RC_OK;
        end
    end

endmodule

### hdl/nbbr_back.sv
// Back end of the translator: owns the remap table and the scan counters,
// builds the table on scan words and looks it up on translate words.
// Depends on nbbr_pkg and nbbr_ram.
module nbbr_back #(
    parameter int MAX_BLOCKS      = nbbr_pkg::DEF_MAX_BLOCKS,
    parameter int PAGES_PER_BLOCK = nbbr_pkg::DEF_PAGES_PER_BLOCK
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nbbr_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output nbbr_pkg::t_res o_res
);

    import nbbr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W  = (CNT_W > VBLK_W) ? CNT_W : VBLK_W;
    localparam int PGC_W  = BLK_W + OFF_W;

    // good_count, high-water mark of written slots, bad total
    logic [CNT_W-1:0]    r_gc, n_gc, r_hw, n_hw, gc_eff, gc_inc;
    logic [BADCNT_W-1:0] r_bt, n_bt, bt_eff;

    // lookup stage, waiting on the registered RAM read
    logic                r_b_valid;
    t_func               r_b_func;
    logic                r_b_bad;
    t_rc                 r_b_rc;
    logic                r_b_mapped;
    logic [BASE_W-1:0]   r_b_base, r_b_limit;
    logic [OFF_W-1:0]    r_b_off;
    logic [BADCNT_W-1:0] r_b_bad_count;

    logic                issue, b_adv, is_scan;
    logic                wr_en, rd_en;
    logic [BLK_W-1:0]    phys;
    logic [BASE_W-1:0]   phys_ext;
    logic [PGC_W-1:0]    page_full;

    assign b_adv     = r_b_valid && !i_res_full;
    assign issue     = i_cmd_valid && (!r_b_valid || b_adv);
    assign o_cmd_pop = issue;
    assign is_scan   = (i_cmd.func == FUNC_SCAN);

    always_comb begin
        gc_eff = i_cmd.restart ? '0 : r_gc;
        bt_eff = i_cmd.restart ? '0 : r_bt;
        gc_inc = gc_eff + 1'b1;
        n_gc   = r_gc;
        n_hw   = r_hw;
        n_bt   = r_bt;
        wr_en  = 1'b0;
        if (issue && is_scan) begin
            n_gc = gc_eff;
            n_bt = bt_eff;
            if (i_cmd.bad) begin
                if (bt_eff < COUNT_MAX) begin
                    n_bt = bt_eff + 1'b1;
                end
            end else if (gc_eff < CNT_W'(MAX_BLOCKS)) begin
                wr_en = 1'b1;
                n_gc  = gc_inc;
                if (gc_inc > r_hw) begin
                    n_hw = gc_inc;
                end
            end
        end
    end

    assign rd_en = issue && !is_scan && (i_cmd.rc == RC_OK);

    nbbr_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (gc_eff[ADDR_W-1:0]),
        .i_wr_data (i_cmd.blk),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_cmd.vblk[ADDR_W-1:0]),
        .o_rd_data (phys)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc      <= '0;
            r_hw      <= '0;
            r_bt      <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_gc <= n_gc;
            r_hw <= n_hw;
            r_bt <= n_bt;
            if (issue) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_func      <= i_cmd.func;
            r_b_bad       <= i_cmd.bad;
            r_b_rc        <= i_cmd.rc;
            r_b_mapped    <= (CMP_W'(i_cmd.vblk) < CMP_W'(r_hw));
            r_b_base      <= i_cmd.base;
            r_b_limit     <= i_cmd.limit;
            r_b_off       <= i_cmd.off;
            r_b_bad_count <= n_bt;
        end
    end

    assign phys_ext  = BASE_W'(phys);
    assign page_full = PGC_W'(phys) * PGC_W'(PAGES_PER_BLOCK) + PGC_W'(r_b_off);

    always_comb begin
        o_res.block_bad   = 1'b0;
        o_res.page        = '0;
        o_res.bad_count   = r_b_bad_count;
        o_res.result_code = RC_OK;
        if (r_b_func == FUNC_SCAN) begin
            o_res.block_bad = r_b_bad;
        end else if (r_b_rc != RC_OK) begin
            o_res.result_code = r_b_rc;
        end else if (!r_b_mapped) begin
            o_res.result_code = RC_UNMAPPED;
        end else if (phys_ext < r_b_base || phys_ext >= r_b_limit) begin
            o_res.result_code = RC_RANGE;
        end else if (page_full > PGC_W'(PAGE_MAX)) begin
            o_res.result_code = RC_RANGE;
        end else begin
            o_res.page = page_full[PAGE_W-1:0];
        end
    end

    assign o_res_push = b_adv;

endmodule

### hdl/nand_bad_block_remap_translator.sv
// Top level of the NAND bad-block remap translator: configuration registers,
// input and result queues, front end and back end. Depends on nbbr_pkg,
// nbbr_fifo, nbbr_front and nbbr_back.
//
// Usage:
//   Input side is a queue: drive a word on the i_ field ports with push high;
//   it is taken at a rising edge where full is low. A scan word (i_func 0)
//   reports the marker byte of one block; block 0 restarts the good and bad
//   counts. A translate word (i_func 1) maps a partition sector to a page.
//   Result side is a queue too: while empty is low the oldest result sits on
//   the o_ ports; raise pop to take it. Exactly one result per input word.
//   Path: command queue, lookup stage (registered table read), result queue.
//   Throughput: one word per cycle while the result queue has room, set by the
//   single RAM port pair of the remap table (one write or one read per word).
//   A stalled receiver fills the two-entry result queue, then the one-word
//   lookup stage and the two-entry command queue, after which full rises;
//   nothing is dropped.
//   Reset clears the queues and counters and loads the partition sizes with
//   1, 3 and 124 MB. The table needs no clearing pass: a high-water mark of
//   written slots marks every slot beyond it as unmapped.
//   Write partition sizes through i_cfg_wr_en/i_cfg_idx/i_cfg_data only
//   while the block is idle.
module nand_bad_block_remap_translator #(
    parameter int MAX_BLOCKS      = nbbr_pkg::DEF_MAX_BLOCKS,
    parameter int PAGES_PER_BLOCK = nbbr_pkg::DEF_PAGES_PER_BLOCK,
    parameter int BLOCKS_PER_MB   = nbbr_pkg::DEF_BLOCKS_PER_MB
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [nbbr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nbbr_pkg::CFG_W-1:0]     i_cfg_data,
    // input queue side
    input  logic                           push,
    output logic                           full,
    input  logic                           i_func,
    input  logic [nbbr_pkg::BLK_W-1:0]     i_block_index,
    input  logic [nbbr_pkg::MARK_W-1:0]    i_marker_byte,
    input  logic [nbbr_pkg::PART_W-1:0]    i_partition,
    input  logic [nbbr_pkg::SECTOR_W-1:0]  i_sector,
    // result queue side
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     o_result_code,
    output logic                           o_block_bad,
    output logic [nbbr_pkg::PAGE_W-1:0]    o_page,
    output logic [nbbr_pkg::BADCNT_W-1:0]  o_bad_count
);

    import nbbr_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    // Partition sizes in megabytes
    logic [CFG_W-1:0] r_kernel_mb, r_ramdisk_mb, r_general_mb;

    t_cmd                 front_cmd, back_cmd;
    logic [$bits(t_cmd)-1:0] cmd_q_data;
    logic                 cmd_empty, cmd_pop;
    t_res                 back_res, out_res;
    logic [$bits(t_res)-1:0] res_q_data;
    logic                 res_full, res_push;

    // Hold the sizes; take a write whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mb  <= RST_KERNEL_MB;
            r_ramdisk_mb <= RST_RAMDISK_MB;
            r_general_mb <= RST_GENERAL_MB;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_KERNEL:  r_kernel_mb  <= i_cfg_data;
                CFG_RAMDISK: r_ramdisk_mb <= i_cfg_data;
                CFG_GENERAL: r_general_mb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the incoming word: partition window, virtual block, early errors
    nbbr_front #(
        .MAX_BLOCKS      (MAX_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .BLOCKS_PER_MB   (BLOCKS_PER_MB)
    ) u_front (
        .i_func        (i_func),
        .i_block_index (i_block_index),
        .i_marker_byte (i_marker_byte),
        .i_partition   (i_partition),
        .i_sector      (i_sector),
        .i_kernel_mb   (r_kernel_mb),
        .i_ramdisk_mb  (r_ramdisk_mb),
        .i_general_mb  (r_general_mb),
        .o_cmd         (front_cmd)
    );

    // Decouple the front from the table stage; its full is the input full
    nbbr_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q_data),
        .o_empty (cmd_empty)
    );

    assign back_cmd = t_cmd'(cmd_q_data);

    // Build the table on scan words, look it up on translate words
    nbbr_back #(
        .MAX_BLOCKS      (MAX_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Hold finished results until the receiver pops them
    nbbr_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q_data),
        .o_empty (empty)
    );

    assign out_res       = t_res'(res_q_data);
    assign o_result_code = out_res.result_code;
    assign o_block_bad   = out_res.block_bad;
    assign o_page        = out_res.page;
    assign o_bad_count   = out_res.bad_count;

endmodule

### tb/sv/nand_bad_block_remap_translator_tb.sv
// Self-checking testbench for nand_bad_block_remap_translator: directed words, then
// random scan runs and translations checked against a behavioural predictor.
// Depends on nbbr_pkg and the translator RTL.
module nand_bad_block_remap_translator_tb;
    import nbbr_pkg::*;

    localparam int N_BLOCKS = DEF_MAX_BLOCKS;
    localparam int PPB      = DEF_PAGES_PER_BLOCK;
    localparam int BPM      = DEF_BLOCKS_PER_MB;

    localparam logic [PART_W-1:0] PART_NONE = 2'd3;   // no such partition
    localparam logic [15:0]       UNMAPPED  = 16'hFFFF;
    localparam int                DIR_ROWS  = 21;

    // One input word as offered on the push side
    typedef struct packed {
        t_func               func;
        logic [BLK_W-1:0]    blk;
        logic [MARK_W-1:0]   mark;
        logic [PART_W-1:0]   part;
        logic [SECTOR_W-1:0] sector;
    } t_nand_op;

    // Directed row: a word and, where obvious, the result typed in by hand
    typedef struct packed {
        t_nand_op op;
        logic     typed;
        t_res     want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  push;
    logic                  full;
    logic                  i_func;
    logic [BLK_W-1:0]      i_block_index;
    logic [MARK_W-1:0]     i_marker_byte;
    logic [PART_W-1:0]     i_partition;
    logic [SECTOR_W-1:0]   i_sector;
    logic                  empty;
    logic                  pop;
    logic [1:0]            o_result_code;
    logic                  o_block_bad;
    logic [PAGE_W-1:0]     o_page;
    logic [BADCNT_W-1:0]   o_bad_count;

    // Predictor state: shadow of the remap table, counters and partition sizes
    logic [15:0]           remap_shadow [0:N_BLOCKS-1];
    int                    next_slot;
    logic [BADCNT_W-1:0]   bad_seen;
    logic [CFG_W-1:0]      part_mb [0:2];

    t_res                  results_q [$];   // expected results, oldest first
    t_dir_row              dir_rows [DIR_ROWS];
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    hold_left;       // receiver hold-off, counted down by the receiver
    int                    errors;
    int                    words_in;
    int                    results_seen;

    nand_bad_block_remap_translator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_block_index (i_block_index),
        .i_marker_byte (i_marker_byte),
        .i_partition   (i_partition),
        .i_sector      (i_sector),
        .empty         (empty),
        .pop           (pop),
        .o_result_code (o_result_code),
        .o_block_bad   (o_block_bad),
        .o_page        (o_page),
        .o_bad_count   (o_bad_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the predictor by one accepted word and return the result it causes.
    function automatic t_res predict_result(input t_nand_op op);
        t_res r;
        int   base;
        int   span;
        int   vblk;
        int   phys;
        int   pg;
        r = '0;
        r.result_code = RC_OK;
        if (op.func == FUNC_SCAN) begin
            // block 0 restarts both counts; the table keeps its contents
            if (op.blk == '0) begin
                next_slot = 0;
                bad_seen  = '0;
            end
            if (op.mark != GOOD_MARK) begin
                r.block_bad = 1'b1;
                if (bad_seen < COUNT_MAX)
                    bad_seen = bad_seen + 1'b1;
            end else if (next_slot < N_BLOCKS) begin
                remap_shadow[next_slot] = {3'b000, op.blk};
                next_slot++;
            end
        end else if (op.part == PART_NONE) begin
            r.result_code = RC_BAD_PART;
        end else begin
            case (op.part)
                PART_KERNEL: begin
                    base = 0;
                    span = int'(part_mb[CFG_KERNEL]) * BPM;
                end
                PART_RAMDISK: begin
                    base = int'(part_mb[CFG_KERNEL]) * BPM;
                    span = int'(part_mb[CFG_RAMDISK]) * BPM;
                end
                default: begin
                    base = (int'(part_mb[CFG_KERNEL]) + int'(part_mb[CFG_RAMDISK])) * BPM;
                    span = int'(part_mb[CFG_GENERAL]) * BPM;
                end
            endcase
            vblk = base + int'(op.sector) / PPB;
            if (vblk >= N_BLOCKS) begin
                r.result_code = RC_RANGE;
            end else begin
                phys = int'(remap_shadow[vblk]);
                if (phys == int'(UNMAPPED)) begin
                    r.result_code = RC_UNMAPPED;
                end else if (phys < base || phys >= base + span) begin
                    r.result_code = RC_RANGE;
                end else begin
                    pg = phys * PPB + int'(op.sector) % PPB;
                    if (pg > PAGE_MAX)
                        r.result_code = RC_RANGE;
                    else
                        r.page = pg[PAGE_W-1:0];
                end
            end
        end
        r.bad_count = bad_seen;
        return r;
    endfunction

    // Scan word for one block; good_pct sets the odds of a 0xFF marker.
    function automatic t_nand_op scan_op(input int blk, input int good_pct);
        t_nand_op op;
        op.func   = FUNC_SCAN;
        op.blk    = blk[BLK_W-1:0];
        op.mark   = ($urandom_range(0, 99) < good_pct) ? GOOD_MARK
                                                       : MARK_W'($urandom_range(0, 254));
        op.part   = PART_W'($urandom);
        op.sector = SECTOR_W'($urandom);
        return op;
    endfunction

    // Translate word aimed at the current span of its partition, a little past it too.
    function automatic t_nand_op xlate_op();
        t_nand_op op;
        int       p;
        int       span;
        int       vb;
        p = $urandom_range(0, 15);
        op.func = FUNC_XLATE;
        op.blk  = BLK_W'($urandom);
        op.mark = MARK_W'($urandom);
        if (p == 0) begin
            op.part = PART_NONE;
            span    = BPM;
        end else begin
            op.part = PART_W'(p % 3);
            span    = int'(part_mb[p % 3]) * BPM;
        end
        vb = $urandom_range(0, span + 1);
        op.sector = SECTOR_W'(vb * PPB + $urandom_range(0, PPB - 1));
        return op;
    endfunction

    function automatic t_nand_op noise_op();
        t_nand_op op;
        op.func   = t_func'($urandom_range(0, 1));
        op.blk    = BLK_W'($urandom);
        op.mark   = MARK_W'($urandom);
        op.part   = PART_W'($urandom);
        op.sector = SECTOR_W'($urandom);
        return op;
    endfunction

    // Offer one word, idling first at random; hold it until the block takes it,
    // then queue the expected result (the typed-in one where given).
    task automatic offer(input t_nand_op op, input logic typed = 1'b0,
                         input t_res want = '0);
        t_res r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_func        <= op.func;
        i_block_index <= op.blk;
        i_marker_byte <= op.mark;
        i_partition   <= op.part;
        i_sector      <= op.sector;
        do @(posedge i_clk); while (full);
        r = predict_result(op);
        results_q.push_back(typed ? want : r);
        words_in++;
    endtask

    // Stop offering, wait for every expected word, then allow for latency.
    task automatic settle();
        push <= 1'b0;
        while (results_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three partition sizes on consecutive edges; only call when idle.
    task automatic set_sizes(input int k, input int r, input int g);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_KERNEL;
        i_cfg_data  <= CFG_W'(k);
        @(posedge i_clk);
        part_mb[CFG_KERNEL] = CFG_W'(k);
        i_cfg_idx  <= CFG_RAMDISK;
        i_cfg_data <= CFG_W'(r);
        @(posedge i_clk);
        part_mb[CFG_RAMDISK] = CFG_W'(r);
        i_cfg_idx  <= CFG_GENERAL;
        i_cfg_data <= CFG_W'(g);
        @(posedge i_clk);
        part_mb[CFG_GENERAL] = CFG_W'(g);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Well-formed phase: restart, a sequential scan burst, then a mix of further
    // scans, translations and junk words. Optionally starve the receiver midway.
    task automatic run_phase(input int n, input logic holdoff);
        int blk;
        int burst;
        int r;
        blk   = 0;
        burst = $urandom_range(40, 80);
        offer(scan_op(0, 85));
        for (int i = 0; i < n; i++) begin
            if (holdoff && i == n / 2)
                hold_left = 200;
            r = $urandom_range(0, 99);
            if (i < burst || r < 25) begin
                if (blk < N_BLOCKS - 1)
                    blk++;
                offer(scan_op(blk, 85));
            end else if (r < 37) begin
                offer(noise_op());
            end else begin
                offer(xlate_op());
            end
        end
    endtask

    // Result side: check the accepted word against the oldest expectation, then
    // decide pop for the next edge (held low during a hold-off).
    initial begin
        t_res want;
        t_res got;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.result_code = t_rc'(o_result_code);
                got.block_bad   = o_block_bad;
                got.page        = o_page;
                got.bad_count   = o_bad_count;
                results_seen++;
                if (results_q.size() == 0) begin
                    $display("%0t: unexpected result word, code %0d page %0d", $time,
                             o_result_code, o_page);
                    errors++;
                end else begin
                    want = results_q.pop_front();
                    if (got.result_code != want.result_code) begin
                        $display("%0t: result_code expected %0d, got %0d", $time,
                                 want.result_code, got.result_code);
                        errors++;
                    end
                    if (got.block_bad != want.block_bad) begin
                        $display("%0t: block_bad expected %0d, got %0d", $time,
                                 want.block_bad, got.block_bad);
                        errors++;
                    end
                    if (got.page != want.page) begin
                        $display("%0t: page expected %0d, got %0d", $time,
                                 want.page, got.page);
                        errors++;
                    end
                    if (got.bad_count != want.bad_count) begin
                        $display("%0t: bad_count expected %0d, got %0d", $time,
                                 want.bad_count, got.bad_count);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #1000000;
        $display("nand_bad_block_remap_translator_tb failed");
        $finish;
    end

    initial begin
        // Hold every input at a known value from time zero
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_idx     <= CFG_KERNEL;
        i_cfg_data    <= '0;
        i_func        <= FUNC_SCAN;
        i_block_index <= '0;
        i_marker_byte <= '0;
        i_partition   <= '0;
        i_sector      <= '0;
        errors        = 0;
        words_in      = 0;
        results_seen  = 0;
        hold_left     = 0;
        send_idle_pct = 20;
        recv_idle_pct = 61;
        for (int i = 0; i < N_BLOCKS; i++)
            remap_shadow[i] = UNMAPPED;
        next_slot = 0;
        bad_seen  = '0;
        part_mb[CFG_KERNEL]  = RST_KERNEL_MB;
        part_mb[CFG_RAMDISK] = RST_RAMDISK_MB;
        part_mb[CFG_GENERAL] = RST_GENERAL_MB;

        // Directed words under reset sizes (1, 3 and 124 MB). Typed-in rows are
        // the obvious ones: errors on an empty table and plain scan counts.
        dir_rows = '{
            // invalid partition, empty table, index beyond the table
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_NONE, 18'd0}, 1'b1,
              '{RC_BAD_PART, 1'b0, 18'd0, 14'd0}},
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_UNMAPPED, 1'b0, 18'd0, 14'd0}},
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_GENERAL, 18'h3FFFF}, 1'b1,
              '{RC_RANGE, 1'b0, 18'd0, 14'd0}},
            // scan restart with a good block, then bad markers of several shapes
            '{'{FUNC_SCAN, 13'd0, 8'hFF, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b0, 18'd0, 14'd0}},
            '{'{FUNC_SCAN, 13'd1, 8'h00, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b1, 18'd0, 14'd1}},
            '{'{FUNC_SCAN, 13'd2, 8'hFE, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b1, 18'd0, 14'd2}},
            '{'{FUNC_SCAN, 13'd3, 8'h7F, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b1, 18'd0, 14'd3}},
            '{'{FUNC_SCAN, 13'd4, 8'hFF, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b0, 18'd0, 14'd3}},
            // top block, with junk in the fields a scan ignores
            '{'{FUNC_SCAN, 13'h1FFF, 8'hFF, PART_NONE, 18'h3FFFF}, 1'b1,
              '{RC_OK, 1'b0, 18'd0, 14'd3}},
            // lookups: mapped, page offset, outside partition, unmapped, bad partition
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_KERNEL, 18'd0}, 1'b0, '0},
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_KERNEL, 18'd33}, 1'b0, '0},
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_KERNEL, 18'd95}, 1'b0, '0},
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_RAMDISK, 18'd0}, 1'b0, '0},
            '{'{FUNC_XLATE, 13'h1FFF, 8'h00, PART_NONE, 18'h3FFFF}, 1'b1,
              '{RC_BAD_PART, 1'b0, 18'd0, 14'd3}},
            // restart with a bad block; the table is kept, slot 0 is overwritten
            '{'{FUNC_SCAN, 13'd0, 8'h00, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b1, 18'd0, 14'd1}},
            '{'{FUNC_SCAN, 13'd5, 8'hFF, PART_KERNEL, 18'd0}, 1'b0, '0},
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_KERNEL, 18'd31}, 1'b0, '0},
            '{'{FUNC_XLATE, 13'd0, 8'h00, PART_GENERAL, 18'd0}, 1'b0, '0},
            '{'{FUNC_SCAN, 13'h1555, 8'hAA, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b1, 18'd0, 14'd2}},
            '{'{FUNC_SCAN, 13'h0AAA, 8'h55, PART_KERNEL, 18'd0}, 1'b1,
              '{RC_OK, 1'b1, 18'd0, 14'd3}},
            '{'{FUNC_XLATE, 13'h1FFF, 8'hFF, PART_KERNEL, 18'h2AAAA}, 1'b0, '0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
        settle();

        // Small partitions; sender idles lightly, receiver heavily, with one long
        // receiver hold-off so the queues fill and full rises.
        set_sizes(1, 1, 2);
        run_phase(140, 1'b1);
        settle();

        // Empty kernel partition; swap the idling odds.
        send_idle_pct = 61;
        recv_idle_pct = 20;
        set_sizes(0, 2, 1);
        run_phase(140, 1'b0);
        settle();

        // Sizes of 128 MB push the upper partitions past the table; no idling.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_sizes(128, 128, 128);
        run_phase(140, 1'b0);
        settle();

        // One partition spans the whole device: a fresh run of random good blocks,
        // a run of bad ones on top, then translate across all of it.
        set_sizes(128, 0, 0);
        offer(scan_op(0, 100));
        for (int i = 0; i < 40; i++)
            offer(scan_op($urandom_range(1, N_BLOCKS - 1), 100));
        for (int i = 0; i < 20; i++)
            offer(scan_op($urandom_range(1, N_BLOCKS - 1), 0));
        for (int i = 0; i < 50; i++)
            offer(xlate_op());
        settle();

        $display("Covered %0d words and %0d results: directed cases, three size layouts",
                 words_in, results_seen);
        $display("under varied back-pressure, and a partition spanning the whole device.");
        if (errors == 0)
            $display("nand_bad_block_remap_translator_tb passed");
        else
            $display("nand_bad_block_remap_translator_tb failed");
        $finish;
    end

endmodule
